// ===== rtl/tmcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Trimmed mean channel scanner package
// Widths, register indexes, reset values and shared types of the scanner.
// ----------------------------------------------------------------------------
package tmcs_pkg;

   localparam int unsigned DEFAULT_SAMPLES_PER_BURST = 10;
   localparam int unsigned DEFAULT_NUM_SLOTS = 6;

   localparam int unsigned SAMPLE_W = 12;
   localparam int unsigned SUM_W = 16;
   localparam int unsigned COUNT_W = 4;
   localparam int unsigned SLOT_W = 3;
   localparam int unsigned CHAN_W = 3;
   localparam int unsigned MAP_W = 18;
   localparam int unsigned MV_W = 12;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 18;

   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_MAP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_MIDPOINT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_SCALE_MV = 2'd2;

   localparam logic [MAP_W-1:0] CHANNEL_MAP_RESET = 18'd256776;
   localparam logic [SAMPLE_W-1:0] REF_MIDPOINT_RESET = 12'd2048;
   localparam logic [SAMPLE_W-1:0] FULL_SCALE_MV_RESET = 12'd3300;

   // Shift of the fixed-point reciprocal used for the burst division.
   localparam int unsigned RECIP_SHIFT = 21;
   localparam int unsigned RECIP_W = RECIP_SHIFT + 1;

   typedef struct packed {
      logic                valid;
      logic [SUM_W-1:0]    trimmed;
      logic [SLOT_W-1:0]   slot;
      logic                round_done;
      logic [CHAN_W-1:0]   next_mux_channel;
   } burst_type;

endpackage

// ===== rtl/tmcs_if.sv =====
// ----------------------------------------------------------------------------
// Trimmed mean channel scanner channels
// Valid/ready interfaces for the sample items and the result items.
// ----------------------------------------------------------------------------
interface tmcs_req_if import tmcs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface tmcs_rsp_if import tmcs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SLOT_W-1:0]   slot;
   logic [SAMPLE_W-1:0] average;
   logic [CHAN_W-1:0]   next_mux_channel;
   logic                round_done;
   logic                ref_above;
   logic [MV_W-1:0]     ref_millivolts;

   modport source (output valid, output slot, output average, output next_mux_channel,
                   output round_done, output ref_above, output ref_millivolts,
                   input ready);
   modport sink (input valid, input slot, input average, input next_mux_channel,
                 input round_done, input ref_above, input ref_millivolts,
                 output ready);
endinterface

// ===== rtl/tmcs_accum.sv =====
// ----------------------------------------------------------------------------
// Burst accumulator
// Tracks minimum, maximum and sum of the current burst and the slot index,
// and registers the trimmed sum of each completed burst.
// ----------------------------------------------------------------------------
module tmcs_accum import tmcs_pkg::*; #(
   parameter int unsigned SAMPLES_PER_BURST = DEFAULT_SAMPLES_PER_BURST,
   parameter int unsigned NUM_SLOTS = DEFAULT_NUM_SLOTS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [SAMPLE_W-1:0] sample,
   input  logic [MAP_W-1:0]    channel_map,
   input  logic                burst_ready,
   output logic                take_ready,
   output burst_type           burst
);

   localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(SAMPLES_PER_BURST - 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

   function automatic logic [CHAN_W-1:0] map_channel(input logic [MAP_W-1:0] map,
                                                     input logic [SLOT_W-1:0] slot);
      logic [CHAN_W-1:0] chan;
      unique case (slot)
         3'd0: chan = map[2:0];
         3'd1: chan = map[5:3];
         3'd2: chan = map[8:6];
         3'd3: chan = map[11:9];
         3'd4: chan = map[14:12];
         3'd5: chan = map[17:15];
         default: chan = '0;
      endcase
      return chan;
   endfunction

   logic [SAMPLE_W-1:0] min_ff, min_in, min_seen;
   logic [SAMPLE_W-1:0] max_ff, max_in, max_seen;
   logic [SUM_W-1:0]    sum_ff, sum_in, sum_seen;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in, slot_next;
   logic                last_sample;
   logic                round_end;
   logic                valid_ff, valid_in;
   logic                load;
   logic [SUM_W-1:0]    trimmed_ff, trimmed_in;
   logic [SLOT_W-1:0]   done_slot_ff;
   logic                round_done_ff;
   logic [CHAN_W-1:0]   next_chan_ff, next_chan_in;

   assign min_seen = (sample < min_ff) ? sample : min_ff;
   assign max_seen = (sample > max_ff) ? sample : max_ff;
   assign sum_seen = sum_ff + SUM_W'(sample);
   assign last_sample = (count_ff == LAST_COUNT);
   assign round_end = (slot_ff == LAST_SLOT);
   assign slot_next = round_end ? '0 : slot_ff + 1'b1;
   assign load = take && last_sample;
   assign trimmed_in = sum_seen - SUM_W'(min_seen) - SUM_W'(max_seen);
   assign next_chan_in = map_channel(channel_map, slot_next);
   assign take_ready = !valid_ff || burst_ready;

   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      sum_in = sum_ff;
      count_in = count_ff;
      slot_in = slot_ff;
      if (take) begin
         if (last_sample) begin
            min_in = '1;
            max_in = '0;
            sum_in = '0;
            count_in = '0;
            slot_in = slot_next;
         end else begin
            min_in = min_seen;
            max_in = max_seen;
            sum_in = sum_seen;
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (burst_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '1;
         max_ff <= '0;
         sum_ff <= '0;
         count_ff <= '0;
         slot_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         min_ff <= min_in;
         max_ff <= max_in;
         sum_ff <= sum_in;
         count_ff <= count_in;
         slot_ff <= slot_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         trimmed_ff <= trimmed_in;
         done_slot_ff <= slot_ff;
         round_done_ff <= round_end;
         next_chan_ff <= next_chan_in;
      end
   end

   assign burst.valid = valid_ff;
   assign burst.trimmed = trimmed_ff;
   assign burst.slot = done_slot_ff;
   assign burst.round_done = round_done_ff;
   assign burst.next_mux_channel = next_chan_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LAST_COUNT)
      else $error("sample count beyond burst length");

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= LAST_SLOT)
      else $error("slot index beyond last slot");

   a_min_max: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 |-> min_ff <= max_ff)
      else $error("burst minimum above burst maximum");

endmodule

// ===== rtl/trimmed_mean_channel_scanner.sv =====
// ----------------------------------------------------------------------------
// Trimmed mean channel scanner
// Averages bursts of converter samples per channel slot with the extremes
// dropped, and reports slot zero against a midpoint in millivolts.
// ----------------------------------------------------------------------------
// One sample item is accepted every cycle. Every SAMPLES_PER_BURST-th item
// completes a burst and yields one result item: the accumulator registers
// the trimmed sum, a reciprocal multiply stage forms the average, and the
// scaling multiply stage fills the output register.
// Each stage moves on as soon as the next one has room, so the sample side
// stalls only when all three stages hold results that the sink has not taken.
module trimmed_mean_channel_scanner import tmcs_pkg::*; #(
   parameter int unsigned SAMPLES_PER_BURST = DEFAULT_SAMPLES_PER_BURST,
   parameter int unsigned NUM_SLOTS = DEFAULT_NUM_SLOTS
) (
   input  logic                  clock,
   input  logic                  reset,
   tmcs_req_if.sink              req_chan,
   tmcs_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned DIVISOR = SAMPLES_PER_BURST - 2;
   localparam int unsigned RECIP_INT = ((1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_INT);
   localparam int unsigned PROD_W = SUM_W + RECIP_W;
   localparam int unsigned MV_PROD_W = 2 * SAMPLE_W;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

   logic [MAP_W-1:0]    channel_map_ff;
   logic [SAMPLE_W-1:0] ref_midpoint_ff;
   logic [SAMPLE_W-1:0] full_scale_mv_ff;

   burst_type           burst;
   logic                burst_ready;
   logic                take;
   logic                take_ready;

   logic                s2_valid_ff, s2_valid_in;
   logic                s2_free, s2_load;
   logic [SAMPLE_W-1:0] s2_avg_ff;
   logic [SLOT_W-1:0]   s2_slot_ff;
   logic                s2_done_ff;
   logic [CHAN_W-1:0]   s2_chan_ff;
   logic [SAMPLE_W-1:0] ref_average_ff;
   logic [PROD_W-1:0]   avg_prod;
   logic [SAMPLE_W-1:0] avg_in;

   logic                out_valid_ff, out_valid_in;
   logic                out_free, out_load;
   logic [SLOT_W-1:0]   out_slot_ff;
   logic [SAMPLE_W-1:0] out_avg_ff;
   logic [CHAN_W-1:0]   out_chan_ff;
   logic                out_done_ff;
   logic                out_above_ff, above_in;
   logic [MV_W-1:0]     out_mv_ff, mv_in;
   logic [SAMPLE_W-1:0] diff;
   logic [MV_PROD_W-1:0] mv_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_map_ff <= CHANNEL_MAP_RESET;
         ref_midpoint_ff <= REF_MIDPOINT_RESET;
         full_scale_mv_ff <= FULL_SCALE_MV_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CHANNEL_MAP: channel_map_ff <= csr_wdata[MAP_W-1:0];
            CSR_REF_MIDPOINT: ref_midpoint_ff <= csr_wdata[SAMPLE_W-1:0];
            CSR_FULL_SCALE_MV: full_scale_mv_ff <= csr_wdata[SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   assign take = req_chan.valid && take_ready;
   assign req_chan.ready = take_ready;

   tmcs_accum #(
      .SAMPLES_PER_BURST (SAMPLES_PER_BURST),
      .NUM_SLOTS         (NUM_SLOTS)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .sample      (req_chan.sample),
      .channel_map (channel_map_ff),
      .burst_ready (burst_ready),
      .take_ready  (take_ready),
      .burst       (burst)
   );

   // Division by the burst length less two as a multiply by a rounded-up
   // reciprocal; exact for every 16-bit trimmed sum.
   assign avg_prod = PROD_W'(burst.trimmed) * PROD_W'(RECIP);
   assign avg_in = avg_prod[RECIP_SHIFT +: SAMPLE_W];

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign out_load = s2_valid_ff && out_free;
   assign s2_free = !s2_valid_ff || out_free;
   assign s2_load = burst.valid && s2_free;
   assign burst_ready = s2_free;

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (s2_load) begin
         s2_valid_in = 1'b1;
      end else if (out_load) begin
         s2_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         ref_average_ff <= '0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         out_valid_ff <= out_valid_in;
         if (s2_load && burst.slot == '0) begin
            ref_average_ff <= avg_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_avg_ff <= avg_in;
         s2_slot_ff <= burst.slot;
         s2_done_ff <= burst.round_done;
         s2_chan_ff <= burst.next_mux_channel;
      end
   end

   // The slot zero average of the item in this stage is already in
   // ref_average_ff, so a single slot round needs no bypass.
   always_comb begin
      above_in = 1'b0;
      diff = ref_midpoint_ff - ref_average_ff;
      if (ref_average_ff > ref_midpoint_ff) begin
         above_in = s2_done_ff;
         diff = ref_average_ff - ref_midpoint_ff;
      end
   end

   assign mv_prod = MV_PROD_W'(diff) * MV_PROD_W'(full_scale_mv_ff);
   assign mv_in = s2_done_ff ? mv_prod[MV_PROD_W-1 -: MV_W] : '0;

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_slot_ff <= s2_slot_ff;
         out_avg_ff <= s2_avg_ff;
         out_chan_ff <= s2_chan_ff;
         out_done_ff <= s2_done_ff;
         out_above_ff <= above_in;
         out_mv_ff <= mv_in;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.slot = out_slot_ff;
   assign rsp_chan.average = out_avg_ff;
   assign rsp_chan.next_mux_channel = out_chan_ff;
   assign rsp_chan.round_done = out_done_ff;
   assign rsp_chan.ref_above = out_above_ff;
   assign rsp_chan.ref_millivolts = out_mv_ff;

   a_round_slot: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_done_ff |-> out_slot_ff == LAST_SLOT)
      else $error("round ended on a slot other than the last");

   a_ref_quiet: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_done_ff |-> !out_above_ff && out_mv_ff == '0)
      else $error("reference fields set outside round end");

   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !out_free |=> s2_valid_ff && $stable(s2_avg_ff))
      else $error("average stage lost a waiting item");

endmodule

// ===== bench/tmcs_result_checker.sv =====
// ----------------------------------------------------------------------------
// Trimmed mean scanner result checker
// Watches the sample, result and register ports of the scanner, predicts every
// burst result from its own copy of the registers and burst state, and
// compares each result item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tmcs_result_checker import tmcs_pkg::*; #(
   parameter int unsigned SAMPLES_PER_BURST = DEFAULT_SAMPLES_PER_BURST,
   parameter int unsigned NUM_SLOTS = DEFAULT_NUM_SLOTS
) (
   input  logic                  clock,
   input  logic                  reset,
   tmcs_req_if                   req_mon,
   tmcs_rsp_if                   rsp_mon,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int unsigned           failures,
   output int unsigned           pending_results
);

   typedef struct packed {
      logic [SLOT_W-1:0]   slot;
      logic [SAMPLE_W-1:0] average;
      logic [CHAN_W-1:0]   next_mux_channel;
      logic                round_done;
      logic                ref_above;
      logic [MV_W-1:0]     ref_millivolts;
   } scan_result_type;

   scan_result_type     expected_results[$];
   int unsigned         fail_count = 0;

   logic [MAP_W-1:0]    slot_channels;
   logic [SAMPLE_W-1:0] zero_code;
   logic [SAMPLE_W-1:0] scale_mv;

   logic [SAMPLE_W-1:0] burst_low;
   logic [SAMPLE_W-1:0] burst_high;
   logic [SUM_W-1:0]    burst_total;
   logic [COUNT_W-1:0]  burst_fill;
   logic [SLOT_W-1:0]   active_slot;
   logic [SAMPLE_W-1:0] slot0_mean;

   task automatic restart_burst();
      burst_low = '1;
      burst_high = '0;
      burst_total = '0;
      burst_fill = '0;
   endtask

   task automatic absorb_sample(input logic [SAMPLE_W-1:0] sample);
      scan_result_type     res;
      logic [SUM_W-1:0]    trimmed;
      logic [SAMPLE_W-1:0] mean;
      logic [SLOT_W-1:0]   upcoming;
      logic [SAMPLE_W-1:0] offset;
      logic [2*SAMPLE_W-1:0] product;
      if (sample > burst_high) begin
         burst_high = sample;
      end
      if (sample < burst_low) begin
         burst_low = sample;
      end
      burst_total = burst_total + SUM_W'(sample);
      if (int'(burst_fill) + 1 < int'(SAMPLES_PER_BURST)) begin
         burst_fill = burst_fill + 1'b1;
      end else begin
         trimmed = burst_total - SUM_W'(burst_low) - SUM_W'(burst_high);
         mean = SAMPLE_W'(trimmed / SUM_W'(SAMPLES_PER_BURST - 2));
         restart_burst();
         res = '0;
         res.slot = active_slot;
         res.average = mean;
         if (active_slot == '0) begin
            slot0_mean = mean;
         end
         upcoming = active_slot + 1'b1;
         if (int'(upcoming) >= int'(NUM_SLOTS)) begin
            upcoming = '0;
            res.round_done = 1'b1;
         end
         active_slot = upcoming;
         res.next_mux_channel = CHAN_W'(slot_channels >> (3 * (int'(upcoming) % 6)));
         if (res.round_done) begin
            res.ref_above = slot0_mean > zero_code;
            offset = res.ref_above ? slot0_mean - zero_code : zero_code - slot0_mean;
            product = (2*SAMPLE_W)'(offset) * (2*SAMPLE_W)'(scale_mv);
            res.ref_millivolts = MV_W'(product >> 12);
         end
         expected_results.push_back(res);
      end
   endtask

   task automatic check_result();
      scan_result_type got;
      scan_result_type want;
      got.slot = rsp_mon.slot;
      got.average = rsp_mon.average;
      got.next_mux_channel = rsp_mon.next_mux_channel;
      got.round_done = rsp_mon.round_done;
      got.ref_above = rsp_mon.ref_above;
      got.ref_millivolts = rsp_mon.ref_millivolts;
      if (expected_results.size() == 0) begin
         if (fail_count < 10) begin
            $display("Unexpected result: slot %0d avg %0d chan %0d done %0b above %0b mv %0d",
                     got.slot, got.average, got.next_mux_channel, got.round_done,
                     got.ref_above, got.ref_millivolts);
         end
         fail_count++;
      end else begin
         want = expected_results.pop_front();
         if (got !== want) begin
            if (fail_count < 10) begin
               $display("Expected: slot %0d avg %0d chan %0d done %0b above %0b mv %0d",
                        want.slot, want.average, want.next_mux_channel, want.round_done,
                        want.ref_above, want.ref_millivolts);
               $display("Actual:   slot %0d avg %0d chan %0d done %0b above %0b mv %0d",
                        got.slot, got.average, got.next_mux_channel, got.round_done,
                        got.ref_above, got.ref_millivolts);
            end
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         slot_channels = CHANNEL_MAP_RESET;
         zero_code = REF_MIDPOINT_RESET;
         scale_mv = FULL_SCALE_MV_RESET;
         restart_burst();
         active_slot = '0;
         slot0_mean = '0;
         expected_results.delete();
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_CHANNEL_MAP: slot_channels = csr_wdata[MAP_W-1:0];
               CSR_REF_MIDPOINT: zero_code = csr_wdata[SAMPLE_W-1:0];
               CSR_FULL_SCALE_MV: scale_mv = csr_wdata[SAMPLE_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            absorb_sample(req_mon.sample);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_result();
         end
      end
      pending_results <= expected_results.size();
      failures <= fail_count;
   end

endmodule

// ===== bench/trimmed_mean_channel_scanner_test.sv =====
// ----------------------------------------------------------------------------
// Trimmed mean scanner testbench
// Drives bursts of converter samples into the scanner under several register
// settings and idle patterns, while a checker module predicts and compares
// every result item. Reports the verdict once all results have drained.
// ----------------------------------------------------------------------------
module trimmed_mean_channel_scanner_test;
   import tmcs_pkg::*;

   localparam int unsigned BURST_LEN = DEFAULT_SAMPLES_PER_BURST;
   localparam int unsigned BURSTS_PER_PHASE = 34;
   localparam int unsigned PHASE_COUNT = 6;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned WATCHDOG_LIMIT = 5000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  sink_ready = 1'b0;
   int unsigned           sender_idle_pct = 7;
   int unsigned           sink_idle_pct = 72;
   int unsigned           stall_cycles = 0;
   int unsigned           failures;
   int unsigned           pending_results;
   logic [SAMPLE_W-1:0]   current_midpoint;

   tmcs_req_if req_chan ();
   tmcs_rsp_if rsp_chan ();

   assign rsp_chan.ready = sink_ready;

   trimmed_mean_channel_scanner i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tmcs_result_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .failures        (failures),
      .pending_results (pending_results)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      sink_ready <= ($urandom_range(99) >= sink_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [MAP_W-1:0] map,
                                 input logic [SAMPLE_W-1:0] midpoint,
                                 input logic [SAMPLE_W-1:0] full_scale);
      write_register(CSR_CHANNEL_MAP, CSR_DATA_W'(map));
      write_register(CSR_REF_MIDPOINT, CSR_DATA_W'(midpoint));
      write_register(CSR_FULL_SCALE_MV, CSR_DATA_W'(full_scale));
      csr_wr_en <= 1'b0;
      current_midpoint = midpoint;
   endtask

   task automatic send_sample(input logic [SAMPLE_W-1:0] value);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.sample <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_random_burst();
      int unsigned mode;
      int          base;
      int          value;
      mode = $urandom_range(9);
      base = $urandom_range(4095);
      if (mode <= 1 && $urandom_range(1) == 1) begin
         base = current_midpoint;
      end
      for (int i = 0; i < BURST_LEN; i++) begin
         case (mode)
            0, 1: value = base;
            6: value = ($urandom_range(1) == 1) ? 4095 : 0;
            7, 8: value = base + $urandom_range(64) - 32;
            default: value = $urandom_range(4095);
         endcase
         if (value < 0) begin
            value = 0;
         end else if (value > 4095) begin
            value = 4095;
         end
         send_sample(SAMPLE_W'(value));
      end
   endtask

   task automatic configure_phase(input int unsigned phase);
      case (phase)
         0: apply_settings(MAP_W'($urandom_range(18'h3FFFF)), 12'd2048, 12'd3300);
         1: apply_settings(18'h3FFFF, 12'd0, 12'd4095);
         2: apply_settings(18'h00000, 12'd4095, 12'd0);
         3: apply_settings(MAP_W'($urandom_range(18'h3FFFF)), SAMPLE_W'($urandom_range(4095)),
                           SAMPLE_W'($urandom_range(4095)));
         4: apply_settings(MAP_W'($urandom_range(18'h3FFFF)), 12'd1, 12'd4095);
         default: apply_settings(CHANNEL_MAP_RESET, REF_MIDPOINT_RESET, FULL_SCALE_MV_RESET);
      endcase
      if (phase < 2) begin
         sender_idle_pct <= 7;
         sink_idle_pct <= 72;
      end else if (phase < 4) begin
         sender_idle_pct <= 72;
         sink_idle_pct <= 7;
      end else begin
         sender_idle_pct <= 0;
         sink_idle_pct <= 0;
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.sample <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_CHANNEL_MAP;
      csr_wdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      apply_settings(CHANNEL_MAP_RESET, REF_MIDPOINT_RESET, FULL_SCALE_MV_RESET);

      for (int i = 0; i < BURST_LEN; i++) send_sample(12'hFFF);
      for (int i = 0; i < BURST_LEN; i++) send_sample(12'h000);
      send_sample(12'h000);
      send_sample(12'hFFF);
      for (int i = 2; i < BURST_LEN; i++) send_sample(12'd2048);
      wait_for_drain();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         configure_phase(phase);
         for (int b = 0; b < BURSTS_PER_PHASE; b++) begin
            send_random_burst();
            if (phase == 2 && b == BURSTS_PER_PHASE / 2) begin
               wait_for_drain();
            end
         end
         wait_for_drain();
      end

      if (failures == 0 && pending_results == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
